### rtl/ordlst_pkg.sv
// Package with shared constants, codes and pointer helpers for the ordered list.
`timescale 1ns / 1ps
`default_nettype none
package ordlst_pkg;

    // List geometry.
    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 31;

    // Command codes.
    typedef enum logic [1:0] {
        CMD_PUSH_FRONT = 2'd0,
        CMD_PUSH_BACK  = 2'd1,
        CMD_REMOVE     = 2'd2,
        CMD_DUMP       = 2'd3
    } cmd_t;

    // Status codes.
    typedef enum logic [2:0] {
        STS_DONE       = 3'd0,
        STS_FULL       = 3'd1,
        STS_NOT_FOUND  = 3'd2,
        STS_DUMP_ENTRY = 3'd3,
        STS_DUMP_EMPTY = 3'd4
    } status_t;

    // Sequencer states, one-hot.
    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_SCAN_RD  = 8'b0000_0010,
        ST_SCAN_CMP = 8'b0000_0100,
        ST_SHF_RD   = 8'b0000_1000,
        ST_SHF_WR   = 8'b0001_0000,
        ST_DUMP_RD  = 8'b0010_0000,
        ST_DUMP_OUT = 8'b0100_0000,
        ST_RESP     = 8'b1000_0000
    } state_t;

    // Physical slot of a logical position in the circular store.
    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] offs);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(offs);
        if (sum >= (CNT_W+1)'(CAPACITY)) begin
            sum = sum - (CNT_W+1)'(CAPACITY);
        end
        return IDX_W'(sum);
    endfunction

endpackage
`default_nettype wire

### rtl/ordlst_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ordlst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

### rtl/ordered_list_push_remove.sv
// Top level of the bounded ordered list with push, remove and dump commands.
//
// The command channel (cmd_valid, cmd_stall, command, value) takes one beat per
// command; the result channel (rsp_valid, rsp_stall, status, entry, count, last)
// gives one beat for a push or remove and one beat per entry for a dump, or a
// single beat for a dump of an empty list. The final beat of a command has last
// set. The entries live in a circular RAM with a head pointer and a fill count,
// so a push writes one slot. A remove reads the list one entry at a time until
// it finds the value, then moves every later entry down one slot. A dump reads
// one entry and puts it into the output register before it reads the next. The
// RAM's single read port with its registered read data sets this pacing. A new
// command is taken once the previous one has put its final beat into the output
// register. After reset the list is empty and no beat is pending; the RAM
// contents need no clearing. When the receiver stalls, the beat waits in the
// output register and the sequencer holds before it gives its next beat.
`timescale 1ns / 1ps
`default_nettype none
module ordered_list_push_remove (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cmd_valid,
    output logic                              cmd_stall,
    input  wire logic [1:0]                   command,
    input  wire logic [ordlst_pkg::VAL_W-1:0] value,
    output logic                              rsp_valid,
    input  wire logic                         rsp_stall,
    output logic [2:0]                        status,
    output logic [ordlst_pkg::VAL_W-1:0]      entry,
    output logic [4:0]                        count,
    output logic                              last
);

    localparam int IDX_W = ordlst_pkg::IDX_W;
    localparam int CNT_W = ordlst_pkg::CNT_W;
    localparam int VAL_W = ordlst_pkg::VAL_W;

    ordlst_pkg::state_t  state_reg, state_next;
    logic [IDX_W-1:0]    head_reg, head_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [CNT_W-1:0]    pos_reg, pos_next;
    logic [VAL_W-1:0]    key_reg, key_next;
    ordlst_pkg::status_t sts_reg, sts_next;

    logic                rsp_valid_reg, rsp_valid_next;
    ordlst_pkg::status_t rsp_status_reg, rsp_status_next;
    logic [VAL_W-1:0]    rsp_entry_reg, rsp_entry_next;
    logic [4:0]          rsp_count_reg, rsp_count_next;
    logic                rsp_last_reg, rsp_last_next;

    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [VAL_W-1:0]    wr_data;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic [VAL_W-1:0]    rd_data;

    logic                cmd_take;
    logic                out_free;
    logic                is_full;

    ordlst_ram #(
        .WIDTH (VAL_W),
        .DEPTH (ordlst_pkg::CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Handshake helpers.
    assign cmd_stall = (state_reg != ordlst_pkg::ST_IDLE);
    assign cmd_take  = cmd_valid && !cmd_stall;
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign is_full   = (fill_reg == CNT_W'(ordlst_pkg::CAPACITY));

    // Sequencer: commands, list scan, entry shift and dump.
    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        fill_next       = fill_reg;
        pos_next        = pos_reg;
        key_next        = key_reg;
        sts_next        = sts_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        rsp_status_next = rsp_status_reg;
        rsp_entry_next  = rsp_entry_reg;
        rsp_count_next  = rsp_count_reg;
        rsp_last_next   = rsp_last_reg;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = value;
        rd_en           = 1'b0;
        rd_addr         = ordlst_pkg::slot_of(head_reg, pos_reg);

        unique case (state_reg)
            ordlst_pkg::ST_IDLE:
            begin
                if (cmd_take) begin
                    key_next = value;
                    pos_next = '0;
                    unique case (ordlst_pkg::cmd_t'(command))
                        ordlst_pkg::CMD_PUSH_FRONT:
                        begin
                            state_next = ordlst_pkg::ST_RESP;
                            if (is_full) begin
                                sts_next = ordlst_pkg::STS_FULL;
                            end else begin
                                sts_next  = ordlst_pkg::STS_DONE;
                                head_next = (head_reg == '0) ?
                                            IDX_W'(ordlst_pkg::CAPACITY - 1) :
                                            head_reg - IDX_W'(1);
                                wr_en     = 1'b1;
                                wr_addr   = head_next;
                                fill_next = fill_reg + CNT_W'(1);
                            end
                        end
                        ordlst_pkg::CMD_PUSH_BACK:
                        begin
                            state_next = ordlst_pkg::ST_RESP;
                            if (is_full) begin
                                sts_next = ordlst_pkg::STS_FULL;
                            end else begin
                                sts_next  = ordlst_pkg::STS_DONE;
                                wr_en     = 1'b1;
                                wr_addr   = ordlst_pkg::slot_of(head_reg, fill_reg);
                                fill_next = fill_reg + CNT_W'(1);
                            end
                        end
                        ordlst_pkg::CMD_REMOVE:
                        begin
                            state_next = ordlst_pkg::ST_SCAN_RD;
                        end
                        ordlst_pkg::CMD_DUMP:
                        begin
                            if (fill_reg == '0) begin
                                sts_next   = ordlst_pkg::STS_DUMP_EMPTY;
                                state_next = ordlst_pkg::ST_RESP;
                            end else begin
                                state_next = ordlst_pkg::ST_DUMP_RD;
                            end
                        end
                        default:
                        begin
                            state_next = ordlst_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            // Read the next entry of the search, or give up at the end.
            ordlst_pkg::ST_SCAN_RD:
            begin
                if (pos_reg == fill_reg) begin
                    sts_next   = ordlst_pkg::STS_NOT_FOUND;
                    state_next = ordlst_pkg::ST_RESP;
                end else begin
                    rd_en      = 1'b1;
                    state_next = ordlst_pkg::ST_SCAN_CMP;
                end
            end

            ordlst_pkg::ST_SCAN_CMP:
            begin
                if (rd_data == key_reg) begin
                    sts_next = ordlst_pkg::STS_DONE;
                    if (pos_reg + CNT_W'(1) < fill_reg) begin
                        state_next = ordlst_pkg::ST_SHF_RD;
                    end else begin
                        fill_next  = fill_reg - CNT_W'(1);
                        state_next = ordlst_pkg::ST_RESP;
                    end
                end else begin
                    pos_next   = pos_reg + CNT_W'(1);
                    state_next = ordlst_pkg::ST_SCAN_RD;
                end
            end

            // Move the entry after the gap down by one position.
            ordlst_pkg::ST_SHF_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = ordlst_pkg::slot_of(head_reg, pos_reg + CNT_W'(1));
                state_next = ordlst_pkg::ST_SHF_WR;
            end

            ordlst_pkg::ST_SHF_WR:
            begin
                wr_en    = 1'b1;
                wr_addr  = ordlst_pkg::slot_of(head_reg, pos_reg);
                wr_data  = rd_data;
                pos_next = pos_reg + CNT_W'(1);
                if (pos_reg + CNT_W'(2) < fill_reg) begin
                    state_next = ordlst_pkg::ST_SHF_RD;
                end else begin
                    fill_next  = fill_reg - CNT_W'(1);
                    state_next = ordlst_pkg::ST_RESP;
                end
            end

            // Dump: read one entry once the output register will be free.
            ordlst_pkg::ST_DUMP_RD:
            begin
                if (out_free) begin
                    rd_en      = 1'b1;
                    state_next = ordlst_pkg::ST_DUMP_OUT;
                end
            end

            ordlst_pkg::ST_DUMP_OUT:
            begin
                rsp_valid_next  = 1'b1;
                rsp_status_next = ordlst_pkg::STS_DUMP_ENTRY;
                rsp_entry_next  = rd_data;
                rsp_count_next  = 5'(fill_reg);
                rsp_last_next   = (pos_reg + CNT_W'(1) == fill_reg);
                pos_next        = pos_reg + CNT_W'(1);
                state_next      = rsp_last_next ? ordlst_pkg::ST_IDLE :
                                                  ordlst_pkg::ST_DUMP_RD;
            end

            // Single status beat.
            ordlst_pkg::ST_RESP:
            begin
                if (out_free) begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = sts_reg;
                    rsp_entry_next  = '0;
                    rsp_count_next  = 5'(fill_reg);
                    rsp_last_next   = 1'b1;
                    state_next      = ordlst_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = ordlst_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ordlst_pkg::ST_IDLE;
            head_reg      <= '0;
            fill_reg      <= '0;
            pos_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            pos_reg       <= pos_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        sts_reg        <= sts_next;
        rsp_status_reg <= rsp_status_next;
        rsp_entry_reg  <= rsp_entry_next;
        rsp_count_reg  <= rsp_count_next;
        rsp_last_reg   <= rsp_last_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign status    = rsp_status_reg;
    assign entry     = rsp_entry_reg;
    assign count     = rsp_count_reg;
    assign last      = rsp_last_reg;

    // The list never holds more than its capacity.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(ordlst_pkg::CAPACITY))
        else $error("fill count above capacity");

    // A dump beat is only produced into an empty output register.
    a_dump_slot: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ordlst_pkg::ST_DUMP_OUT |-> !rsp_valid_reg)
        else $error("dump beat would overwrite a pending beat");

    // A remove that ends with a shift shrinks the list by exactly one.
    a_remove_dec: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ordlst_pkg::ST_SHF_WR && state_next == ordlst_pkg::ST_RESP
        |=> fill_reg == $past(fill_reg) - CNT_W'(1))
        else $error("remove did not decrement the fill count");

endmodule
`default_nettype wire
